// ===== src/dbd_pkg.sv =====
// Shared types, constants and the month table for the day difference block.
package dbd_pkg;

  // Field widths
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned DAYS_W  = 23;
  localparam int unsigned WDAY_W  = 3;

  // Day number width: covers every 14-bit year
  localparam int unsigned NUM_W   = 23;
  // Signed difference width, one sign bit over the day number
  localparam int unsigned DIFF_W  = NUM_W + 1;

  localparam int unsigned YEAR_LIMIT_DEFAULT = 9999;

  // Largest difference magnitude that is passed through
  localparam int unsigned DIFF_MAX = 4194303;

  // Reciprocal of 100: exact floor for every 14-bit year
  localparam int unsigned RECIP_100   = 5243;
  localparam int unsigned RECIP_W     = 13;
  localparam int unsigned RECIP_SHIFT = 19;

  // Days in a year, and weekday bias so that 2000-01-02 lands on Sunday
  localparam int unsigned DAYS_PER_YEAR = 365;
  localparam int unsigned WDAY_BIAS     = 2;
  localparam int unsigned DAYS_PER_WEEK = 7;

  localparam int unsigned MOFF_W = 9;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } date_t;

  // Days from March 1 to the first of the month, March-based year.
  // Month zero reads as January, months above 12 as December.
  function automatic logic [MOFF_W-1:0] month_offset(input logic [MONTH_W-1:0] m);
    logic [MOFF_W-1:0] off;
    case (m) inside
      4'd0, 4'd1:      off = 9'd306;
      4'd2:            off = 9'd337;
      4'd3:            off = 9'd0;
      4'd4:            off = 9'd31;
      4'd5:            off = 9'd61;
      4'd6:            off = 9'd92;
      4'd7:            off = 9'd122;
      4'd8:            off = 9'd153;
      4'd9:            off = 9'd184;
      4'd10:           off = 9'd214;
      4'd11:           off = 9'd245;
      [4'd12:4'd15]:   off = 9'd275;
      default:         off = 9'd0;
    endcase
    return off;
  endfunction

endpackage

// ===== src/dbd_chan_if.sv =====
// Request and response channel interfaces of the day difference block.
interface dbd_in_if;
  import dbd_pkg::*;
  logic               valid;
  logic               ready;
  logic [YEAR_W-1:0]  year_a;
  logic [MONTH_W-1:0] month_a;
  logic [DAY_W-1:0]   day_a;
  logic [YEAR_W-1:0]  year_b;
  logic [MONTH_W-1:0] month_b;
  logic [DAY_W-1:0]   day_b;

  modport source (output valid, year_a, month_a, day_a, year_b, month_b, day_b,
                  input ready);
  modport sink   (input valid, year_a, month_a, day_a, year_b, month_b, day_b,
                  output ready);
endinterface

interface dbd_out_if;
  import dbd_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DAYS_W-1:0] days_between;
  logic [WDAY_W-1:0]        weekday_a;

  modport source (output valid, days_between, weekday_a, input ready);
  modport sink   (input valid, days_between, weekday_a, output ready);
endinterface

// ===== src/days_between_dates.sv =====
// Top level: two date lanes feeding the difference and weekday merge stage.
//
//   channel  dir  payload                                        handshake
//   req_i    in   year_a month_a day_a year_b month_b day_b      valid/ready
//   rsp_o    out  days_between weekday_a                         valid/ready
//
// One request per cycle while responses are taken; a taken request passes through
// the lane day-number register, then the merge output register, to its response.
// Reset clears only the stage valid flags; no storage needs clearing.
// A stalled response holds the output register, and the lane stage stalls
// behind it once it also holds a request.
module days_between_dates
  import dbd_pkg::*;
#(
  parameter int unsigned YEAR_LIMIT = YEAR_LIMIT_DEFAULT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  dbd_in_if.sink    req_i,
  dbd_out_if.source rsp_o
);

  logic             s1_valid_q;
  logic             s1_ready;
  logic             merge_ready;
  logic             load;
  date_t            date_a, date_b;
  logic [NUM_W-1:0] num_a, num_b;

  // Lane stage control
  assign s1_ready    = !s1_valid_q || merge_ready;
  assign req_i.ready = s1_ready;
  assign load        = req_i.valid && s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= req_i.valid;
    end
  end

  assign date_a = '{year: req_i.year_a, month: req_i.month_a, day: req_i.day_a};
  assign date_b = '{year: req_i.year_b, month: req_i.month_b, day: req_i.day_b};

  // Day-number lanes
  dbd_lane #(.YEAR_LIMIT(YEAR_LIMIT)) u_lane_a (
    .clk_i  (clk_i),
    .load_i (load),
    .date_i (date_a),
    .num_o  (num_a)
  );

  dbd_lane #(.YEAR_LIMIT(YEAR_LIMIT)) u_lane_b (
    .clk_i  (clk_i),
    .load_i (load),
    .date_i (date_b),
    .num_o  (num_b)
  );

  // Merge and output
  dbd_merge u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s1_valid_q),
    .in_ready_o (merge_ready),
    .num_a_i    (num_a),
    .num_b_i    (num_b),
    .rsp_o      (rsp_o)
  );

  // A lane result held back by the merge stage stays put
  a_lane_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !merge_ready) |=> (s1_valid_q && $stable(num_a) && $stable(num_b)))
    else $error("lane stage changed while stalled");

endmodule

// ===== src/dbd_lane.sv =====
// One lane: converts a date into a March-based day number, registered.
module dbd_lane
  import dbd_pkg::*;
#(
  parameter int unsigned YEAR_LIMIT = YEAR_LIMIT_DEFAULT
) (
  input  logic             clk_i,
  input  logic             load_i,
  input  date_t            date_i,
  output logic [NUM_W-1:0] num_o
);

  localparam int unsigned LimEff = (YEAR_LIMIT < 1) ? 1 : YEAR_LIMIT;
  localparam logic [16:0] LimW   = 17'(LimEff);

  logic [YEAR_W-1:0]             year_c;
  logic [YEAR_W-1:0]             year_adj;
  logic                          early;
  logic [YEAR_W+RECIP_W-1:0]     q_prod;
  logic [YEAR_W-1:0]             q100;
  logic [NUM_W:0]                sum;
  logic [NUM_W-1:0]              num_d, num_q;

  // Clamp year into 1..limit
  always_comb begin
    year_c = date_i.year;
    if (date_i.year == '0) begin
      year_c = YEAR_W'(1);
    end else if ({3'b000, date_i.year} > LimW) begin
      year_c = LimW[YEAR_W-1:0];
    end
  end

  // January and February count with the previous year
  assign early    = (date_i.month < MONTH_W'(3));
  assign year_adj = early ? (year_c - YEAR_W'(1)) : year_c;

  // Century count by reciprocal multiply
  assign q_prod = {{RECIP_W{1'b0}}, year_adj} * (YEAR_W + RECIP_W)'(RECIP_100);
  assign q100   = YEAR_W'(q_prod >> RECIP_SHIFT);

  // 365y + y/4 - y/100 + y/400 + month offset + day
  always_comb begin
    sum = (NUM_W + 1)'(year_adj) * (NUM_W + 1)'(DAYS_PER_YEAR)
        + (NUM_W + 1)'(year_adj >> 2)
        - (NUM_W + 1)'(q100)
        + (NUM_W + 1)'(q100 >> 2)
        + (NUM_W + 1)'(month_offset(date_i.month))
        + (NUM_W + 1)'(date_i.day);
    num_d = sum[NUM_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      num_q <= num_d;
    end
  end

  assign num_o = num_q;

endmodule

// ===== src/dbd_merge.sv =====
// Merge stage: day difference with saturation, weekday, output register.
module dbd_merge
  import dbd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [NUM_W-1:0] num_a_i,
  input  logic [NUM_W-1:0] num_b_i,
  dbd_out_if.source        rsp_o
);

  localparam logic signed [DIFF_W-1:0] DiffMax = DIFF_W'(DIFF_MAX);

  logic signed [DIFF_W-1:0] diff;
  logic signed [DIFF_W-1:0] diff_sat;
  logic [NUM_W:0]           wd_x;
  logic [5:0]               wd_s1;
  logic [3:0]               wd_s2;
  logic [WDAY_W-1:0]        wd;

  logic                     valid_q;
  logic [DAYS_W-1:0]        days_d, days_q;
  logic [WDAY_W-1:0]        wday_q;

  // Signed difference, clipped to plus or minus DIFF_MAX inside the field range
  always_comb begin
    diff = $signed({1'b0, num_a_i}) - $signed({1'b0, num_b_i});
    diff_sat = diff;
    if (diff > DiffMax) begin
      diff_sat = DiffMax;
    end else if (diff < -DiffMax) begin
      diff_sat = -DiffMax;
    end
    days_d = diff_sat[DAYS_W-1:0];
  end

  // Mod 7 by folding octal digits (8 = 1 mod 7)
  always_comb begin
    wd_x  = (NUM_W + 1)'(num_a_i) + (NUM_W + 1)'(WDAY_BIAS);
    wd_s1 = 6'(wd_x[2:0])   + 6'(wd_x[5:3])   + 6'(wd_x[8:6])   + 6'(wd_x[11:9])
          + 6'(wd_x[14:12]) + 6'(wd_x[17:15]) + 6'(wd_x[20:18]) + 6'(wd_x[23:21]);
    wd_s2 = 4'(wd_s1[2:0]) + 4'(wd_s1[5:3]);
    if (wd_s2 >= 4'(DAYS_PER_WEEK)) begin
      wd = WDAY_W'(wd_s2 - 4'(DAYS_PER_WEEK));
    end else begin
      wd = wd_s2[WDAY_W-1:0];
    end
  end

  // Output register, refills when empty or while the current response is taken
  assign in_ready_o = !valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      days_q <= days_d;
      wday_q <= wd;
    end
  end

  assign rsp_o.valid        = valid_q;
  assign rsp_o.days_between = $signed(days_q);
  assign rsp_o.weekday_a    = wday_q;

  // Checks
  a_wday_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (wday_q < WDAY_W'(DAYS_PER_WEEK)))
    else $error("weekday out of range");

  a_days_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (($signed(days_q) <= $signed(DiffMax[DAYS_W-1:0]))
              && ($signed(days_q) >= -$signed(DiffMax[DAYS_W-1:0]))))
    else $error("day difference beyond saturation bound");

endmodule
